>>> hw/rtl/cqf_pkg.sv
package cqf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_DISPLAY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  // request to load the output register
  typedef struct packed {
    logic    vld;
    logic    from_mem;
    status_t status;
    logic    last;
  } out_load_t;

endpackage

>>> hw/rtl/cqf_ram.sv
module cqf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/cqf_out_reg.sv
module cqf_out_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cqf_pkg::out_load_t                  load,
  input  logic [cqf_pkg::DATA_W-1:0]          rdata,
  output logic                                out_free,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic signed [cqf_pkg::DATA_W-1:0]   out_tdata,
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast
);

  logic                               valid_r;
  logic                               valid_nxt;
  logic signed [cqf_pkg::DATA_W-1:0]  data_r;
  logic signed [cqf_pkg::DATA_W-1:0]  data_nxt;
  cqf_pkg::status_t                   status_r;
  cqf_pkg::status_t                   status_nxt;
  logic                               last_r;
  logic                               last_nxt;

  assign out_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt  = valid_r;
    data_nxt   = data_r;
    status_nxt = status_r;
    last_nxt   = last_r;
    if (load.vld) begin
      valid_nxt  = 1'b1;
      data_nxt   = load.from_mem ? rdata : '0;
      status_nxt = load.status;
      last_nxt   = load.last;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r   <= data_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = status_r;
  assign out_tlast  = last_r;

endmodule

>>> hw/rtl/cqf_ctrl.sv
module cqf_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  cqf_pkg::cmd_t                     in_cmd,
  input  logic signed [cqf_pkg::DATA_W-1:0] in_value,
  input  logic                              out_free,
  output cqf_pkg::out_load_t                load,
  output logic                              ram_we,
  output logic [cqf_pkg::IDX_W-1:0]         ram_waddr,
  output logic [cqf_pkg::DATA_W-1:0]        ram_wdata,
  output logic                              ram_re,
  output logic [cqf_pkg::IDX_W-1:0]         ram_raddr
);

  localparam logic [cqf_pkg::IDX_W-1:0] LastIdx = cqf_pkg::IDX_W'(cqf_pkg::QUEUE_DEPTH - 1);
  localparam logic [cqf_pkg::CNT_W-1:0] FullCnt = cqf_pkg::CNT_W'(cqf_pkg::QUEUE_DEPTH);

  logic [cqf_pkg::IDX_W-1:0] head_r, head_nxt;
  logic [cqf_pkg::IDX_W-1:0] tail_r, tail_nxt;
  logic [cqf_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [cqf_pkg::IDX_W-1:0] walk_idx_r, walk_idx_nxt;
  logic [cqf_pkg::CNT_W-1:0] walk_left_r, walk_left_nxt;
  logic                      pend_r, pend_nxt;
  logic                      pend_last_r, pend_last_nxt;
  logic                      accept;
  logic                      load_mem;
  logic                      issue_walk;
  logic [cqf_pkg::CNT_W:0]   wrap_sum;
  logic [cqf_pkg::IDX_W-1:0] tail_expect;

  function automatic logic [cqf_pkg::IDX_W-1:0] next_slot(input logic [cqf_pkg::IDX_W-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  assign in_tready  = !pend_r && (walk_left_r == '0) && out_free;
  assign accept     = in_tvalid && in_tready;
  assign load_mem   = pend_r && out_free;
  // next display read goes out as the previous word moves to the output
  assign issue_walk = (walk_left_r != '0) && (!pend_r || out_free);

  assign ram_waddr = tail_r;
  assign ram_wdata = in_value;

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    walk_idx_nxt  = walk_idx_r;
    walk_left_nxt = walk_left_r;
    pend_nxt      = pend_r && !load_mem;
    pend_last_nxt = pend_last_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = head_r;
    load.vld      = load_mem;
    load.from_mem = load_mem;
    load.status   = cqf_pkg::ST_OK;
    load.last     = pend_last_r;

    if (issue_walk) begin
      ram_re        = 1'b1;
      ram_raddr     = walk_idx_r;
      walk_idx_nxt  = next_slot(walk_idx_r);
      walk_left_nxt = walk_left_r - 1'b1;
      pend_nxt      = 1'b1;
      pend_last_nxt = (walk_left_r == cqf_pkg::CNT_W'(1));
    end

    if (accept) begin
      case (in_cmd)
        cqf_pkg::CMD_PUSH: begin
          load.vld  = 1'b1;
          load.last = 1'b1;
          if (count_r == FullCnt) begin
            load.status = cqf_pkg::ST_OVERFLOW;
          end else begin
            ram_we    = 1'b1;
            tail_nxt  = next_slot(tail_r);
            count_nxt = count_r + 1'b1;
          end
        end
        cqf_pkg::CMD_POP: begin
          if (count_r == '0) begin
            load.vld    = 1'b1;
            load.status = cqf_pkg::ST_EMPTY;
            load.last   = 1'b1;
          end else begin
            ram_re        = 1'b1;
            head_nxt      = next_slot(head_r);
            count_nxt     = count_r - 1'b1;
            pend_nxt      = 1'b1;
            pend_last_nxt = 1'b1;
          end
        end
        cqf_pkg::CMD_DISPLAY: begin
          if (count_r == '0) begin
            load.vld    = 1'b1;
            load.status = cqf_pkg::ST_EMPTY;
            load.last   = 1'b1;
          end else begin
            ram_re        = 1'b1;
            walk_idx_nxt  = next_slot(head_r);
            walk_left_nxt = count_r - 1'b1;
            pend_nxt      = 1'b1;
            pend_last_nxt = (count_r == cqf_pkg::CNT_W'(1));
          end
        end
        default: begin
          // unused code: dropped without a result
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      walk_left_r <= '0;
      pend_r      <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      walk_left_r <= walk_left_nxt;
      pend_r      <= pend_nxt;
    end
    walk_idx_r  <= walk_idx_nxt;
    pend_last_r <= pend_last_nxt;
  end

  // tail must sit count slots past head, modulo the depth
  assign wrap_sum    = {1'b0, cqf_pkg::CNT_W'(head_r)} + {1'b0, count_r};
  assign tail_expect = (wrap_sum >= (cqf_pkg::CNT_W + 1)'(cqf_pkg::QUEUE_DEPTH))
                     ? cqf_pkg::IDX_W'(wrap_sum - (cqf_pkg::CNT_W + 1)'(cqf_pkg::QUEUE_DEPTH))
                     : cqf_pkg::IDX_W'(wrap_sum);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FullCnt)
    else $error("entry count beyond depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r == tail_expect)
    else $error("head, tail and count disagree");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> count_r < FullCnt)
    else $error("store written while full");

  a_walk_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (walk_left_r != '0 || pend_r) |-> !in_tready)
    else $error("input taken during a read-out");

  a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !out_free) |=> pend_r && $stable(pend_last_r))
    else $error("pending word lost under stall");

endmodule

>>> hw/rtl/circular_queue_fifo_core.sv
// circular queue of signed 32-bit words, 16 deep
// input channel: in_tuser carries the command (push, pop, display), in_tdata
// the word to push; a word is taken when in_tvalid and in_tready are high
// output channel: out_tuser carries the status (ok, overflow, empty),
// out_tdata the popped or displayed word (zero otherwise), out_tlast marks
// the final result of each command
// push, overflow and empty results reach the output register at the accept
// edge: one command per cycle while the receiver keeps up
// pop and display read the entry store (synchronous ram), so their first
// result is registered in the ram read register and then loaded into the
// output register once it is free; a display then streams one word per cycle
// from head to tail while the receiver keeps up, limited by the single ram
// read port, and the next command is taken once its last word is loaded
// an unused command code is taken and gives no result
// reset (rst_n low, synchronous) empties the queue and the output register;
// the stored words are not cleared and no clearing pass is needed
// when the receiver stalls the result stays in the output register, a
// pending ram word waits in the ram read register, and in_tready drops
module circular_queue_fifo_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic signed [cqf_pkg::DATA_W-1:0] in_tdata,   // [31:0] value
  input  logic [1:0]                        in_tuser,   // [1:0] command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic signed [cqf_pkg::DATA_W-1:0] out_tdata,  // [31:0] data
  output logic [1:0]                        out_tuser,  // [1:0] status
  output logic                              out_tlast
);

  cqf_pkg::out_load_t        load;
  logic                      out_free;
  logic                      ram_we;
  logic [cqf_pkg::IDX_W-1:0] ram_waddr;
  logic [cqf_pkg::DATA_W-1:0] ram_wdata;
  logic                      ram_re;
  logic [cqf_pkg::IDX_W-1:0] ram_raddr;
  logic [cqf_pkg::DATA_W-1:0] ram_rdata;

  cqf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (cqf_pkg::cmd_t'(in_tuser)),
    .in_value  (in_tdata),
    .out_free  (out_free),
    .load      (load),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  cqf_ram #(
    .WIDTH (cqf_pkg::DATA_W),
    .DEPTH (cqf_pkg::QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cqf_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .rdata      (ram_rdata),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
